// ----- hw/rtl/binary_morphology_edge_pipeline_macros.svh -----
// Assertion macros shared by the edge pipeline RTL.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef BINARY_MORPHOLOGY_EDGE_PIPELINE_MACROS_SVH
`define BINARY_MORPHOLOGY_EDGE_PIPELINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BMEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmep: assertion failed");

// Next-cycle implication, checked out of reset.
`define BMEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmep: assertion failed");

`endif

// ----- hw/rtl/bmep_pkg.sv -----
// Shared constants, register indexes and geometry type of the edge pipeline.
// No dependencies.
package bmep_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int WORD_BITS   = 32;
    localparam int PASS_COUNT  = 5;
    localparam int MAX_WORDS   = MAX_WIDTH / WORD_BITS;
    localparam int COL_W       = $clog2(MAX_WORDS);
    localparam int WPW_W       = $clog2(MAX_WORDS + 1);
    localparam int PRIME_W     = $clog2(MAX_WORDS + 2);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WIDTH_W     = 9;
    localparam int HEIGHT_W    = 10;
    localparam int ROW_W       = HEIGHT_W;
    localparam int CFG_W       = 10;
    localparam int IDX_W       = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [IDX_W-1:0]    REG_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0]    REG_HEIGHT   = 2'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd188;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd120;

    // bit k set: pass k erodes, else dilates
    localparam logic [PASS_COUNT-1:0] PASS_ERODE = 5'b11001;

    typedef struct packed {
        logic [WPW_W-1:0]     wpw;
        logic [COL_W-1:0]     last_col;
        logic [ROW_W-1:0]     last_row;
        logic [WORD_BITS-1:0] tail_mask;
        logic [BIT_W-1:0]     right_bit;
    } geom_t;

endpackage

// ----- hw/rtl/bmep_pixel_if.sv -----
// Input channel: valid/ready with one packed pixel word per beat.
// Uses bmep_pkg for the word width.
interface bmep_pixel_if;
    import bmep_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

// ----- hw/rtl/bmep_edge_if.sv -----
// Output channel: valid/ready with one edge word and frame marker per beat.
// Uses bmep_pkg for the word width.
interface bmep_edge_if;
    import bmep_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] edge_word;
    logic                 frame_last;

    modport source (output valid, output edge_word, output frame_last, input ready);
    modport sink   (input valid, input edge_word, input frame_last, output ready);
endinterface

// ----- hw/rtl/bmep_front.sv -----
// Front end: config registers, frame geometry, input position and tail masking.
// Depends on bmep_pkg.
module bmep_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [bmep_pkg::IDX_W-1:0]     wr_index,
    input  logic [bmep_pkg::CFG_W-1:0]     wr_data,
    output logic                           restart,
    output bmep_pkg::geom_t                geom,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bmep_pkg::WORD_BITS-1:0] in_word,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [bmep_pkg::WORD_BITS-1:0] push_word
);
    import bmep_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [WIDTH_W-1:0]  weff;
    logic [HEIGHT_W-1:0] heff;
    logic [WIDTH_W:0]    wsum;
    logic                accept;

    // effective geometry
    always_comb
    begin
        if (width_reg == '0)
            weff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            weff = WIDTH_W'(MAX_WIDTH);
        else
            weff = width_reg;
        heff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        wsum = {1'b0, weff} + (WIDTH_W+1)'(WORD_BITS - 1);
        geom.wpw       = WPW_W'(wsum >> BIT_W);
        geom.last_col  = COL_W'(geom.wpw - WPW_W'(1));
        geom.last_row  = heff - HEIGHT_W'(1);
        geom.right_bit = BIT_W'(weff - WIDTH_W'(1));
        if (weff[BIT_W-1:0] == '0)
            geom.tail_mask = '1;
        else
            geom.tail_mask = (WORD_BITS'(1) << weff[BIT_W-1:0]) - WORD_BITS'(1);
    end

    assign restart = wr_en && (wr_index == REG_WIDTH || wr_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WIDTH:  width_reg  <= wr_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= wr_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign accept     = in_valid && push_ready;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_word  = (col_reg == geom.last_col) ? (in_word & geom.tail_mask) : in_word;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == geom.last_col)
            begin
                col_next = '0;
                row_next = (row_reg == geom.last_row) ? '0 : row_reg + ROW_W'(1);
            end
            else
                col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end
endmodule

// ----- hw/rtl/bmep_queue.sv -----
// Short word queue between front end and pass chain.
// Depends on bmep_pkg.
module bmep_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  logic                           push_valid,
    output logic                           push_ready,
    input  logic [bmep_pkg::WORD_BITS-1:0] push_word,
    output logic                           pop_valid,
    input  logic                           pop_ready,
    output logic [bmep_pkg::WORD_BITS-1:0] pop_word
);
    import bmep_pkg::*;

    logic [WORD_BITS-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]      cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign push_ready = cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + (QPTR_W+1)'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else if (restart)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end
endmodule

// ----- hw/rtl/bmep_pass.sv -----
// One 3x3 erode/dilate pass over a word stream, with two row delays,
// a 3x3 word window, border clearing and an end-of-frame flush.
// Depends on bmep_pkg and the assertion macro header.
`include "binary_morphology_edge_pipeline_macros.svh"

module bmep_pass (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  bmep_pkg::geom_t                geom,
    input  logic                           is_erode,
    input  logic                           is_final,
    input  logic                           src_valid,
    output logic                           src_ready,
    input  logic [bmep_pkg::WORD_BITS-1:0] src_word,
    output logic                           dst_valid,
    input  logic                           dst_ready,
    output logic [bmep_pkg::WORD_BITS-1:0] dst_word,
    output logic                           dst_last
);
    import bmep_pkg::*;

    logic [WORD_BITS-1:0] lb1_reg [MAX_WORDS];
    logic [WORD_BITS-1:0] lb2_reg [MAX_WORDS];
    logic [COL_W-1:0]     ptr_reg;
    logic [WORD_BITS-1:0] a1_reg, a2_reg, b1_reg, b2_reg, c1_reg, c2_reg;
    logic [PRIME_W-1:0]   prime_reg;
    logic [COL_W-1:0]     sx_reg, ox_reg;
    logic [ROW_W-1:0]     sy_reg, oy_reg;
    logic                 flush_reg;
    logic [PRIME_W-1:0]   dcnt_reg;
    logic                 dst_valid_reg, dst_last_reg;
    logic [WORD_BITS-1:0] dst_word_reg;

    logic [WORD_BITS-1:0] x, d1, d2;
    logic [WORD_BITS-1:0] bl, br, ml, mr, tl, tr;
    logic [WORD_BITS-1:0] rb, rm, rt, res, outw;
    logic                 emit, slot_free, adv, at_left, at_right, src_end, out_end;

    // sliding 3x3 of one row: {left-shifted, center, right-shifted} combined
    function automatic logic [WORD_BITS-1:0] row_op(input logic ero,
        input logic [WORD_BITS-1:0] c, input logic [WORD_BITS-1:0] l,
        input logic [WORD_BITS-1:0] r);
        logic [WORD_BITS-1:0] lft, rgt;
        lft = {c[WORD_BITS-2:0], l[WORD_BITS-1]};
        rgt = {r[0], c[WORD_BITS-1:1]};
        return ero ? (lft & c & rgt) : (lft | c | rgt);
    endfunction

    always_comb
    begin
        x         = flush_reg ? '0 : src_word;
        d1        = lb1_reg[ptr_reg];
        d2        = lb2_reg[ptr_reg];
        emit      = prime_reg > PRIME_W'(geom.wpw);
        slot_free = !dst_valid_reg || dst_ready;
        src_ready = !flush_reg && (!emit || slot_free);
        adv       = (flush_reg || src_valid) && (!emit || slot_free);
        at_left   = ox_reg == '0;
        at_right  = ox_reg == geom.last_col;
        src_end   = (sx_reg == geom.last_col) && (sy_reg == geom.last_row);
        out_end   = at_right && (oy_reg == geom.last_row);

        // newest word is below-right of the output position
        bl = at_left  ? '0 : a2_reg;
        br = at_right ? '0 : x;
        ml = at_left  ? '0 : b2_reg;
        mr = at_right ? '0 : d1;
        tl = at_left  ? '0 : c2_reg;
        tr = at_right ? '0 : d2;
        rb = row_op(is_erode, a1_reg, bl, br);
        rm = row_op(is_erode, b1_reg, ml, mr);
        rt = row_op(is_erode, c1_reg, tl, tr);
        res = is_erode ? (rb & rm & rt) : (rb | rm | rt);
        if (at_right)
            res = res & geom.tail_mask;
        if (oy_reg == '0 || oy_reg == geom.last_row)
            res = '0;
        if (at_left)
            res[0] = 1'b0;
        if (at_right)
            res[geom.right_bit] = 1'b0;
        // edge: clean center word minus its erosion
        outw = is_final ? (b1_reg & ~res) : res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            prime_reg     <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            flush_reg     <= 1'b0;
            dcnt_reg      <= '0;
            dst_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            ptr_reg       <= '0;
            prime_reg     <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            flush_reg     <= 1'b0;
            dcnt_reg      <= '0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv && emit)
                dst_valid_reg <= 1'b1;
            else if (dst_ready)
                dst_valid_reg <= 1'b0;
            if (adv)
            begin
                ptr_reg <= (ptr_reg == geom.last_col) ? '0 : ptr_reg + COL_W'(1);
                a1_reg  <= x;
                a2_reg  <= a1_reg;
                b1_reg  <= d1;
                b2_reg  <= b1_reg;
                c1_reg  <= d2;
                c2_reg  <= c1_reg;
                if (!emit)
                    prime_reg <= prime_reg + PRIME_W'(1);
                if (emit)
                begin
                    if (at_right)
                    begin
                        ox_reg <= '0;
                        oy_reg <= (oy_reg == geom.last_row) ? '0 : oy_reg + ROW_W'(1);
                    end
                    else
                        ox_reg <= ox_reg + COL_W'(1);
                end
                if (!flush_reg)
                begin
                    if (src_end)
                    begin
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        flush_reg <= 1'b1;
                        dcnt_reg  <= PRIME_W'(geom.wpw) + PRIME_W'(1);
                    end
                    else if (sx_reg == geom.last_col)
                    begin
                        sx_reg <= '0;
                        sy_reg <= sy_reg + ROW_W'(1);
                    end
                    else
                        sx_reg <= sx_reg + COL_W'(1);
                end
                else
                begin
                    dcnt_reg <= dcnt_reg - PRIME_W'(1);
                    if (dcnt_reg == PRIME_W'(1))
                    begin
                        flush_reg <= 1'b0;
                        prime_reg <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lb1_reg[ptr_reg] <= x;
            lb2_reg[ptr_reg] <= d1;
        end
        if (adv && emit)
        begin
            dst_word_reg <= outw;
            dst_last_reg <= out_end;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;
    assign dst_last  = dst_last_reg;

    `BMEP_ASSERT_NOW(a_prime_bound, 1'b1, prime_reg <= PRIME_W'(geom.wpw) + PRIME_W'(1))
    `BMEP_ASSERT_NOW(a_last_on_final_dummy, adv && emit && out_end,
        flush_reg && dcnt_reg == PRIME_W'(1))
    `BMEP_ASSERT_NOW(a_cols_in_row, 1'b1,
        ox_reg <= geom.last_col && sx_reg <= geom.last_col)
    `BMEP_ASSERT_NEXT(a_flush_ends_clean, adv && flush_reg && dcnt_reg == PRIME_W'(1) && !restart,
        !flush_reg && prime_reg == '0)
endmodule

// ----- hw/rtl/binary_morphology_edge_pipeline.sv -----
// Top level of the binary morphology edge pipeline: front end, word queue
// and five chained 3x3 passes. Depends on bmep_pkg, bmep_pixel_if,
// bmep_edge_if, bmep_front, bmep_queue and bmep_pass.
//
//  channel   | dir | beat payload                 | handshake
//  ----------+-----+------------------------------+----------------
//  pixels    | in  | pixel_word[31:0]             | valid/ready
//  edges     | out | edge_word[31:0], frame_last  | valid/ready
//  wr_*      | in  | wr_index[1:0], wr_data[9:0]  | wr_en, no stall
//
// One word per cycle sustained while edges is ready, outside flushes; the
// queue registers each word, each pass lags wpw+1 words (wpw = words per
// row, its two row delays) and registers its output. Each pass runs wpw+1
// zero beats at the last word of a frame; the input stalls once per frame,
// as each later pass flushes while the one before primes the next frame.
// Reset is asynchronous, active low; the row delays need no clearing.
// A width or height write restarts the frame and drops any pending words.
// A stall on edges backs up through the passes into the 4-deep queue.
module binary_morphology_edge_pipeline (
    input  logic                       clk,
    input  logic                       rst_n,
    bmep_pixel_if.sink                 pixels,
    bmep_edge_if.source                edges,
    input  logic                       wr_en,
    input  logic [bmep_pkg::IDX_W-1:0] wr_index,
    input  logic [bmep_pkg::CFG_W-1:0] wr_data
);
    import bmep_pkg::*;

    geom_t                geom;
    logic                 restart;
    logic                 push_valid, push_ready;
    logic [WORD_BITS-1:0] push_word;

    // link k feeds pass k; link PASS_COUNT is the pipeline output
    logic                 lk_valid [PASS_COUNT+1];
    logic                 lk_ready [PASS_COUNT+1];
    logic [WORD_BITS-1:0] lk_word  [PASS_COUNT+1];
    logic                 lk_last  [PASS_COUNT+1];

    bmep_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .restart    (restart),
        .geom       (geom),
        .in_valid   (pixels.valid),
        .in_ready   (pixels.ready),
        .in_word    (pixels.pixel_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    bmep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (lk_valid[0]),
        .pop_ready  (lk_ready[0]),
        .pop_word   (lk_word[0])
    );

    // queue carries no frame marker; passes track position themselves
    assign lk_last[0] = 1'b0;

    // erode, dilate (opening), dilate, erode (closing), erode -> edge
    for (genvar k = 0; k < PASS_COUNT; k++)
    begin : g_pass
        bmep_pass u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .restart   (restart),
            .geom      (geom),
            .is_erode  (PASS_ERODE[k]),
            .is_final  (k == PASS_COUNT - 1),
            .src_valid (lk_valid[k]),
            .src_ready (lk_ready[k]),
            .src_word  (lk_word[k]),
            .dst_valid (lk_valid[k+1]),
            .dst_ready (lk_ready[k+1]),
            .dst_word  (lk_word[k+1]),
            .dst_last  (lk_last[k+1])
        );
    end

    assign edges.valid      = lk_valid[PASS_COUNT];
    assign edges.edge_word  = lk_word[PASS_COUNT];
    assign edges.frame_last = lk_last[PASS_COUNT] && !lk_last[0];
    assign lk_ready[PASS_COUNT] = edges.ready;
endmodule

// ----- bench/binary_morphology_edge_pipeline_tb.sv -----
// Testbench for binary_morphology_edge_pipeline: directed table, then random frames.
// Edge beats are checked against an in-bench five-pass predictor or a typed row.
// Depends on bmep_pkg, bmep_pixel_if, bmep_edge_if and the block RTL.
module binary_morphology_edge_pipeline_tb;
    import bmep_pkg::*;

    localparam int RING_DEPTH  = 32;    // 4 rows of the widest image
    localparam int DRAIN_WAIT  = 120;
    localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side
    localparam int ITEM_TARGET = 230;   // pixel words over the whole run

    // register indexes that the block decodes to nothing
    localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [WORD_BITS-1:0] edge_bits;
        logic                 last;
    } edge_beat_t;

    typedef struct {
        bit                   is_cfg;
        logic [IDX_W-1:0]     idx;
        logic [CFG_W-1:0]     data;
        logic [WORD_BITS-1:0] word;
        bit                   typed;    // expected beat given in the row
        edge_beat_t           beat;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    bmep_pixel_if pix ();
    bmep_edge_if  edg ();

    binary_morphology_edge_pipeline u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pix.sink),
        .edges    (edg.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Edge predictor: its own geometry, position and per-pass word rings.
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]   geo_width;
    logic [HEIGHT_W-1:0]  geo_height;
    int unsigned          next_col;
    int unsigned          next_row;
    logic [WORD_BITS-1:0] word_ring [PASS_COUNT][RING_DEPTH];
    int unsigned          pass_pos  [PASS_COUNT];

    edge_beat_t expected_edges [$];
    int         err_count;

    function automatic int unsigned used_width();
        if (geo_width == 0) return 1;
        if (geo_width > MAX_WIDTH) return MAX_WIDTH;
        return geo_width;
    endfunction

    function automatic int unsigned used_height();
        return (geo_height == 0) ? 1 : geo_height;
    endfunction

    function automatic int unsigned row_word_count();
        return (used_width() + 31) / 32;
    endfunction

    function automatic logic [WORD_BITS-1:0] row_tail_mask();
        int unsigned rem;
        rem = used_width() % 32;
        return (rem != 0) ? ((32'd1 << rem) - 32'd1) : '1;
    endfunction

    // Top and bottom rows go to zero; outer pixels of other rows are cleared.
    function automatic logic [WORD_BITS-1:0] trim_border(logic [WORD_BITS-1:0] v,
                                                         int unsigned y, int unsigned i);
        if (y == 0 || y == used_height() - 1) return '0;
        if (i == 0) v[0] = 1'b0;
        if (i == row_word_count() - 1) v[(used_width() - 1) % 32] = 1'b0;
        return v;
    endfunction

    function automatic logic [WORD_BITS-1:0] ring_word(int s, int y, int i);
        int wpw;
        wpw = row_word_count();
        if (y < 0 || y >= int'(used_height()) || i < 0 || i >= wpw) return '0;
        return word_ring[s][(y * wpw + i) % RING_DEPTH];
    endfunction

    // Word q of the output of pass k, from the ring feeding it.
    function automatic logic [WORD_BITS-1:0] pass_word(int k, int unsigned q);
        int                   wpw;
        int                   y;
        int                   i;
        logic [WORD_BITS-1:0] acc;
        logic [WORD_BITS-1:0] c;
        logic [WORD_BITS-1:0] lw;
        logic [WORD_BITS-1:0] rw;
        logic [WORD_BITS-1:0] sl;
        logic [WORD_BITS-1:0] sr;
        wpw = row_word_count();
        y = q / wpw;
        i = q % wpw;
        acc = PASS_ERODE[k] ? '1 : '0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            c  = ring_word(k, y + dy, i);
            lw = ring_word(k, y + dy, i - 1);
            rw = ring_word(k, y + dy, i + 1);
            sl = (c << 1) | (lw >> 31);
            sr = (c >> 1) | (rw << 31);
            if (PASS_ERODE[k]) acc &= sl & c & sr;
            else               acc |= sl | c | sr;
        end
        if (i == wpw - 1) acc &= row_tail_mask();
        return trim_border(acc, y, i);
    endfunction

    function automatic void restart_geometry();
        next_col = 0;
        next_row = 0;
        foreach (pass_pos[k]) pass_pos[k] = 0;
    endfunction

    function automatic void model_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        if (idx == REG_WIDTH)
        begin
            geo_width = data[WIDTH_W-1:0];
            restart_geometry();
        end
        else if (idx == REG_HEIGHT)
        begin
            geo_height = data[HEIGHT_W-1:0];
            restart_geometry();
        end
    endfunction

    // Advance the passes on one accepted pixel word; push the edge beats it frees.
    function automatic void predict_edges(logic [WORD_BITS-1:0] word, bit keep);
        int unsigned          wpw;
        int unsigned          total;
        int unsigned          n;
        int unsigned          q;
        int unsigned          src;
        int unsigned          need;
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] clean;
        edge_beat_t           b;
        bit                   moved;
        wpw = row_word_count();
        total = wpw * used_height();
        n = next_row * wpw + next_col;
        if (n >= total)
        begin
            restart_geometry();
            n = 0;
        end
        if (next_col == wpw - 1) word &= row_tail_mask();
        word_ring[0][n % RING_DEPTH] = word;
        if (n == total - 1)
        begin
            next_col = 0;
            next_row = 0;
        end
        else
        begin
            next_col = next_col + 1;
            if (next_col >= wpw)
            begin
                next_col = 0;
                next_row = next_row + 1;
            end
        end
        moved = 1'b1;
        while (moved)
        begin
            moved = 1'b0;
            for (int k = 0; k < PASS_COUNT; k++)
            begin
                q = pass_pos[k];
                src = (k == 0) ? n + 1 : pass_pos[k-1];
                need = q + wpw + 1;
                if (q >= total) continue;
                if (need > total - 1) need = total - 1;
                if (src <= need) continue;
                v = pass_word(k, q);
                if (k + 1 < PASS_COUNT)
                    word_ring[k+1][q % RING_DEPTH] = v;
                else
                begin
                    clean = word_ring[PASS_COUNT-1][q % RING_DEPTH];
                    b.edge_bits = trim_border(clean & ~v, q / wpw, q % wpw);
                    b.last = (q == total - 1);
                    if (keep) expected_edges.push_back(b);
                end
                pass_pos[k] = q + 1;
                moved = 1'b1;
            end
        end
        if (n == total - 1) restart_geometry();
    endfunction

    task automatic report(string what);
        $display("MISMATCH t=%0t %s", $time, what);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Edge side: random back-pressure plus one long hold-off on request.
    // ------------------------------------------------------------------
    int unsigned rx_idle_pct;
    int unsigned tx_idle_pct;
    int unsigned hold_req;
    int unsigned hold_left;
    edge_beat_t  got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edg.ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (edg.valid && edg.ready)
            begin
                if (expected_edges.size() == 0)
                    report($sformatf("edge beat %h with nothing expected", edg.edge_word));
                else
                begin
                    got = expected_edges.pop_front();
                    if (edg.edge_word !== got.edge_bits)
                        report($sformatf("edge_word %h, want %h", edg.edge_word, got.edge_bits));
                    if (edg.frame_last !== got.last)
                        report($sformatf("frame_last %b, want %b", edg.frame_last, got.last));
                end
            end
            if (hold_req != 0 && hold_left == 0)
            begin
                hold_left <= hold_req;
                edg.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                edg.ready <= 1'b0;
            end
            else
                edg.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    int unsigned quiet_cycles;
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (edg.valid && edg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("binary_morphology_edge_pipeline_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Pixel side and configuration.
    // ------------------------------------------------------------------
    int unsigned sent;

    task automatic send_word(logic [WORD_BITS-1:0] word, bit keep = 1'b1);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel_word <= word;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        predict_edges(word, keep);
        sent++;
    endtask

    // Registers change only once the block has emptied out.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        pix.valid <= 1'b0;
        @(posedge clk);
        while (expected_edges.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        model_write(idx, data);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_pixels();
        case ($urandom_range(4))
            0:       return '1;
            1:       return $urandom() | $urandom();        // mostly foreground
            2:       return $urandom() & $urandom();        // sparse
            3:       return ~(32'd1 << $urandom_range(31)); // single hole
            default: return $urandom();
        endcase
    endfunction

    // Mostly small frames, now and then extreme; over 48 words cut short, else maybe twice.
    task automatic random_frame();
        int unsigned w;
        int unsigned h;
        int unsigned words;
        case ($urandom_range(9))
            0:       w = MAX_WIDTH;
            1:       w = $urandom_range(257, 511);
            2:       w = 0;
            default: w = $urandom_range(1, 70);
        endcase
        case ($urandom_range(9))
            0:       h = 1023;
            1:       h = 0;
            default: h = $urandom_range(1, 6);
        endcase
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        words = row_word_count() * used_height();
        if (words > 48) words = $urandom_range(10, 48);  // partial frame
        else if ($urandom_range(3) == 0) words = 2 * words;  // two frames back to back
        repeat (words) send_word(pick_pixels());
    endtask

    stim_row_t plan [$];
    edge_beat_t zero_last;

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        pix.valid = 1'b0;
        pix.pixel_word = '0;
        edg.ready = 1'b0;
        err_count = 0;
        sent = 0;
        hold_req = 0;
        quiet_cycles = 0;
        tx_idle_pct = 12;
        rx_idle_pct = 75;
        geo_width = WIDTH_RESET;
        geo_height = HEIGHT_RESET;
        restart_geometry();
        foreach (word_ring[s, j]) word_ring[s][j] = '0;
        zero_last = '{edge_bits: '0, last: 1'b1};

        // One-row images: every pass clears the row, so each word is its own
        // frame with an all-zero edge beat.
        plan.push_back('{1, REG_WIDTH,   10'd32,  '0, 0, '0});
        plan.push_back('{1, REG_HEIGHT,  10'd1,   '0, 0, '0});
        plan.push_back('{0, '0, '0, 32'h0000_0000, 1, zero_last});
        plan.push_back('{0, '0, '0, 32'hFFFF_FFFF, 1, zero_last});
        plan.push_back('{0, '0, '0, 32'hA5A5_5A5A, 1, zero_last});
        // zero width acts as one pixel, zero height as one row
        plan.push_back('{1, REG_WIDTH,   10'd0,   '0, 0, '0});
        plan.push_back('{1, REG_HEIGHT,  10'd0,   '0, 0, '0});
        plan.push_back('{0, '0, '0, 32'hFFFF_FFFF, 1, zero_last});
        // writes to unused indexes change nothing
        plan.push_back('{1, REG_SPARE_A, 10'h3FF, '0, 0, '0});
        plan.push_back('{1, REG_SPARE_B, 10'h155, '0, 0, '0});
        plan.push_back('{0, '0, '0, 32'hFFFF_FFFF, 1, zero_last});
        // two-row image: still all zero, beats follow the predictor
        plan.push_back('{1, REG_WIDTH,   10'd1,   '0, 0, '0});
        plan.push_back('{1, REG_HEIGHT,  10'd2,   '0, 0, '0});
        plan.push_back('{0, '0, '0, 32'hFFFF_FFFF, 0, '0});
        plan.push_back('{0, '0, '0, 32'hFFFF_FFFF, 0, '0});
        // 40x3 solid block with tail bits set on entry
        plan.push_back('{1, REG_WIDTH,   10'd40,  '0, 0, '0});
        plan.push_back('{1, REG_HEIGHT,  10'd3,   '0, 0, '0});
        for (int j = 0; j < 6; j++)
            plan.push_back('{0, '0, '0, 32'hFFFF_FFFF, 0, '0});
        // widest, tallest setting, then width above range (bit 9 dropped)
        plan.push_back('{1, REG_WIDTH,   10'd256, '0, 0, '0});
        plan.push_back('{1, REG_HEIGHT,  10'd1023, '0, 0, '0});
        for (int j = 0; j < 20; j++)
            plan.push_back('{0, '0, '0, (j % 2) ? 32'hFFFF_FFFF : 32'h7FFF_FFFE, 0, '0});
        plan.push_back('{1, REG_WIDTH,   10'h3FF, '0, 0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].is_cfg)
                write_reg(plan[r].idx, plan[r].data);
            else
            begin
                send_word(plan[r].word, !plan[r].typed);
                if (plan[r].typed) expected_edges.push_back(plan[r].beat);
            end
        end

        // Random frames, three idling mixes.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 12; rx_idle_pct = 75; end
                1:       begin tx_idle_pct = 75; rx_idle_pct = 12; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            if (phase == 2)
            begin
                // Long edge hold-off against one and a half 256x6 frames: the
                // passes and the queue fill up and the pixel side must stall.
                write_reg(REG_WIDTH, 10'd256);
                write_reg(REG_HEIGHT, 10'd6);
                hold_req <= 300;
                @(posedge clk);
                hold_req <= 0;
                repeat (72) send_word(pick_pixels());
            end
            while (sent < (phase + 1) * ITEM_TARGET / 3)
                random_frame();
            // sender rests until every pending edge beat is out
            pix.valid <= 1'b0;
            @(posedge clk);
            while (expected_edges.size() != 0) @(posedge clk);
        end

        pix.valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("binary_morphology_edge_pipeline_tb: done, clean");
        else
            $display("binary_morphology_edge_pipeline_tb: done, errors");
        $finish;
    end

endmodule
